// ===== rtl/video_memory_write_port_unit_macros.svh =====
// assertion macros for the video memory write port unit
// used by video_memory_write_port_unit.sv; no other dependencies
`ifndef VIDEO_MEMORY_WRITE_PORT_UNIT_MACROS_SVH
`define VIDEO_MEMORY_WRITE_PORT_UNIT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define VMWP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vmwp assertion failed");
// next-cycle implication
`define VMWP_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vmwp assertion failed");
`else
`define VMWP_ASSERT_IMP(label, clk, rst, ante, cons)
`define VMWP_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/vmwp_pkg.sv =====
// types, register offsets and helper functions for the video memory write port
// no dependencies
package vmwp_pkg;

  localparam int VRAM_BYTES_DEF    = 65536;
  localparam int PALETTE_BYTES_DEF = 512;
  localparam int SPRITE_BYTES_DEF  = 544;

  // raw byte addresses are at most 17 bits wide (vram word plus byte select)
  localparam int ADDR_X_W = 17;
  localparam int RECIP_W  = ADDR_X_W + 1;

  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_VRAM = 2'd1,
    TGT_PAL  = 2'd2,
    TGT_OAM  = 2'd3
  } target_t;

  localparam logic [5:0] OFF_OAM_ADDR_LO = 6'h02;
  localparam logic [5:0] OFF_OAM_ADDR_HI = 6'h03;
  localparam logic [5:0] OFF_OAM_DATA    = 6'h04;
  localparam logic [5:0] OFF_VRAM_CTRL   = 6'h15;
  localparam logic [5:0] OFF_VRAM_ADDR_LO = 6'h16;
  localparam logic [5:0] OFF_VRAM_ADDR_HI = 6'h17;
  localparam logic [5:0] OFF_VRAM_DATA_LO = 6'h18;
  localparam logic [5:0] OFF_VRAM_DATA_HI = 6'h19;
  localparam logic [5:0] OFF_PAL_ADDR    = 6'h21;
  localparam logic [5:0] OFF_PAL_DATA    = 6'h22;

  localparam logic [1:0] REMAP_NONE = 2'd0;
  localparam logic [1:0] REMAP_8    = 2'd1;
  localparam logic [1:0] REMAP_9    = 2'd2;
  localparam logic [1:0] REMAP_10   = 2'd3;

  localparam logic [1:0] INC_1  = 2'd0;
  localparam logic [1:0] INC_32 = 2'd1;

  localparam logic [7:0] PAL_HIGH_MASK = 8'h7F;

  // bit rotation of the low address bits for the three remap modes
  function automatic logic [15:0] remap_word(input logic [15:0] a, input logic [1:0] mode);
    logic [15:0] r;
    case (mode)
      REMAP_8:  r = {a[15:8], a[4:0], a[7:5]};
      REMAP_9:  r = {a[15:9], a[5:0], a[8:6]};
      REMAP_10: r = {a[15:10], a[6:0], a[9:7]};
      default:  r = a;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] step_size(input logic [1:0] inc);
    logic [15:0] s;
    case (inc)
      INC_1:   s = 16'd1;
      INC_32:  s = 16'd32;
      default: s = 16'd128;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/video_memory_write_port_unit.sv =====
// m_tvalid rises once an accepted transaction has moved through stages s1 to s4; a low
// m_tready while m_tvalid is high freezes every stage and s_tready with them
// throughput: one transaction per cycle unless a low m_tready stalls the output; pointer
// updates finish at accept, the remaining stages reduce the byte address modulo the memory size
// (reciprocal multiply, product multiply, one correction subtract)
// reset: synchronous rst clears pointers, port control, palette phase and stage valids
`include "video_memory_write_port_unit_macros.svh"

module video_memory_write_port_unit import vmwp_pkg::*; #(
  parameter int VRAM_BYTES    = VRAM_BYTES_DEF,
  parameter int PALETTE_BYTES = PALETTE_BYTES_DEF,
  parameter int SPRITE_BYTES  = SPRITE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] write_data
  input  logic [7:0]  s_tuser,   // [5:0] reg_offset, [7:6] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [15:0] mem_address, [23:16] mem_data
  output logic [7:0]  m_tuser    // [1:0] target, [7:2] zero
);

  localparam logic [ADDR_X_W-1:0] VRAM_D = ADDR_X_W'(VRAM_BYTES);
  localparam logic [ADDR_X_W-1:0] PAL_D  = ADDR_X_W'(PALETTE_BYTES);
  localparam logic [ADDR_X_W-1:0] OAM_D  = ADDR_X_W'(SPRITE_BYTES);
  localparam logic [RECIP_W-1:0] VRAM_M =
    RECIP_W'((64'd1 << ADDR_X_W) / VRAM_BYTES);
  localparam logic [RECIP_W-1:0] PAL_M =
    RECIP_W'((64'd1 << ADDR_X_W) / PALETTE_BYTES);
  localparam logic [RECIP_W-1:0] OAM_M =
    RECIP_W'((64'd1 << ADDR_X_W) / SPRITE_BYTES);

  // architectural state
  logic [7:0]  vram_ctrl, vram_ctrl_next;
  logic [15:0] vram_ptr, vram_ptr_next;
  logic [15:0] oam_ptr, oam_ptr_next;
  logic [7:0]  pal_ptr, pal_ptr_next;
  logic        pal_phase, pal_phase_next;

  // pipeline
  logic                 s1_valid, s2_valid, s3_valid, s4_valid;
  target_t              s1_tgt, s2_tgt, s3_tgt, s4_tgt;
  logic [ADDR_X_W-1:0]  s1_x, s2_x;
  logic [7:0]           s1_data, s2_data, s3_data, s4_data;
  logic [RECIP_W-1:0]   s2_q;
  logic [RECIP_W-1:0]   s3_rem;
  logic [15:0]          s4_addr;

  target_t              tgt_next;
  logic [ADDR_X_W-1:0]  x_next;
  logic [7:0]           data_next;

  logic                 adv, accept;
  logic [5:0]           offset;
  logic [7:0]           wdata;
  logic                 vram_high;
  logic [15:0]          vram_word;

  logic [RECIP_W-1:0]   s1_m;
  logic [ADDR_X_W-1:0]  s2_d, s3_d;
  logic [ADDR_X_W+RECIP_W-1:0] q_prod;
  logic [ADDR_X_W+RECIP_W-1:0] qd_prod;
  logic [RECIP_W-1:0]   rem_next;
  logic [RECIP_W-1:0]   rem_fixed;

  assign adv      = !s4_valid || m_tready;
  assign s_tready = adv;
  assign accept   = s_tvalid && adv;
  assign offset   = s_tuser[5:0];
  assign wdata    = s_tdata;

  assign vram_high = (offset == OFF_VRAM_DATA_HI);
  assign vram_word = remap_word(vram_ptr, vram_ctrl[3:2]);

  always_comb begin
    vram_ctrl_next = vram_ctrl;
    vram_ptr_next  = vram_ptr;
    oam_ptr_next   = oam_ptr;
    pal_ptr_next   = pal_ptr;
    pal_phase_next = pal_phase;
    tgt_next       = TGT_NONE;
    x_next         = '0;
    data_next      = '0;
    if (accept) begin
      case (offset)
        OFF_OAM_ADDR_LO: begin
          oam_ptr_next = {7'd0, oam_ptr[8], wdata};
        end
        OFF_OAM_ADDR_HI: begin
          oam_ptr_next = {7'd0, wdata[0], oam_ptr[7:0]};
        end
        OFF_OAM_DATA: begin
          tgt_next     = TGT_OAM;
          x_next       = {1'b0, oam_ptr};
          data_next    = wdata;
          oam_ptr_next = oam_ptr + 16'd1;
        end
        OFF_VRAM_CTRL: begin
          vram_ctrl_next = wdata;
        end
        OFF_VRAM_ADDR_LO: begin
          vram_ptr_next = {vram_ptr[15:8], wdata};
        end
        OFF_VRAM_ADDR_HI: begin
          vram_ptr_next = {wdata, vram_ptr[7:0]};
        end
        OFF_VRAM_DATA_LO, OFF_VRAM_DATA_HI: begin
          tgt_next  = TGT_VRAM;
          x_next    = {vram_word, vram_high};
          data_next = wdata;
          // bit 7 of the control byte picks which half advances the pointer
          if (vram_ctrl[7] == vram_high) begin
            vram_ptr_next = vram_ptr + step_size(vram_ctrl[1:0]);
          end
        end
        OFF_PAL_ADDR: begin
          pal_ptr_next   = wdata;
          pal_phase_next = 1'b0;
        end
        OFF_PAL_DATA: begin
          tgt_next       = TGT_PAL;
          x_next         = {8'd0, pal_ptr, pal_phase};
          pal_phase_next = !pal_phase;
          if (pal_phase) begin
            data_next    = wdata & PAL_HIGH_MASK;
            pal_ptr_next = pal_ptr + 8'd1;
          end else begin
            data_next = wdata;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vram_ctrl <= '0;
      vram_ptr  <= '0;
      oam_ptr   <= '0;
      pal_ptr   <= '0;
      pal_phase <= 1'b0;
    end else begin
      vram_ctrl <= vram_ctrl_next;
      vram_ptr  <= vram_ptr_next;
      oam_ptr   <= oam_ptr_next;
      pal_ptr   <= pal_ptr_next;
      pal_phase <= pal_phase_next;
    end
  end

  // modulo reduction: q ~ x / D via reciprocal, rem = x - q*D < 2D, then one fix-up
  always_comb begin
    case (s1_tgt)
      TGT_VRAM: s1_m = VRAM_M;
      TGT_PAL:  s1_m = PAL_M;
      default:  s1_m = OAM_M;
    endcase
    case (s2_tgt)
      TGT_VRAM: s2_d = VRAM_D;
      TGT_PAL:  s2_d = PAL_D;
      default:  s2_d = OAM_D;
    endcase
    case (s3_tgt)
      TGT_VRAM: s3_d = VRAM_D;
      TGT_PAL:  s3_d = PAL_D;
      default:  s3_d = OAM_D;
    endcase
  end

  assign q_prod    = (ADDR_X_W+RECIP_W)'(s1_x) * (ADDR_X_W+RECIP_W)'(s1_m);
  assign qd_prod   = (ADDR_X_W+RECIP_W)'(s2_q) * (ADDR_X_W+RECIP_W)'(s2_d);
  assign rem_next  = {1'b0, s2_x} - qd_prod[RECIP_W-1:0];
  assign rem_fixed = (s3_rem >= {1'b0, s3_d}) ? (s3_rem - {1'b0, s3_d}) : s3_rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s_tvalid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tgt  <= tgt_next;
      s1_x    <= x_next;
      s1_data <= data_next;
      s2_tgt  <= s1_tgt;
      s2_x    <= s1_x;
      s2_data <= s1_data;
      s2_q    <= q_prod[ADDR_X_W+RECIP_W-1:ADDR_X_W];
      s3_tgt  <= s2_tgt;
      s3_data <= s2_data;
      s3_rem  <= rem_next;
      s4_tgt  <= s3_tgt;
      s4_data <= s3_data;
      s4_addr <= rem_fixed[15:0];
    end
  end

  assign m_tvalid = s4_valid;
  assign m_tdata  = {s4_data, s4_addr};
  assign m_tuser  = {6'd0, s4_tgt};

  logic out_none, out_pal, s3_live, pal_write, s3_rem_ok, out_pal_ok;
  assign out_none   = m_tvalid && (s4_tgt == TGT_NONE);
  assign out_pal    = m_tvalid && (s4_tgt == TGT_PAL);
  assign s3_live    = s3_valid;
  assign pal_write  = accept && (offset == OFF_PAL_DATA);
  assign s3_rem_ok  = (s3_rem < {s3_d, 1'b0});
  assign out_pal_ok = ({1'b0, s4_addr} < PAL_D);

  `VMWP_ASSERT_IMP(a_none_is_zero, clk, rst, out_none, m_tdata == 24'd0)
  `VMWP_ASSERT_IMP(a_rem_bound, clk, rst, s3_live, s3_rem_ok)
  `VMWP_ASSERT_IMP(a_pal_in_range, clk, rst, out_pal, out_pal_ok)
  `VMWP_ASSERT_NXT(a_pal_phase_toggle, clk, rst, pal_write, pal_phase != $past(pal_phase))

endmodule

// ===== tb/vmwp_write_checker.sv =====
// scoreboard for the video memory write port: watches both stream channels,
// predicts each memory write command and compares it with the one that comes out
// depends on vmwp_pkg for the target codes, register offsets and memory sizes
`timescale 1ns / 100ps

module vmwp_write_checker import vmwp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] write_data
  input  logic [7:0]  s_tuser,   // [5:0] reg_offset, [7:6] zero
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,   // [15:0] mem_address, [23:16] mem_data
  input  logic [7:0]  m_tuser,   // [1:0] target, [7:2] zero
  output int          mismatch_count,
  output int          outstanding
);

  typedef struct packed {
    target_t     target;
    logic [15:0] addr;
    logic [7:0]  data;
  } mem_cmd_t;

  localparam int REPORT_LIMIT = 10;

  mem_cmd_t    expected_cmds[$];
  logic [7:0]  port_ctrl;
  logic [15:0] vram_ptr;
  logic [15:0] oam_ptr;
  logic [7:0]  pal_ptr;
  logic        pal_high;

  // low word bits rotated for the three remap modes
  function automatic logic [15:0] scrambled_word(input logic [15:0] a, input logic [1:0] mode);
    case (mode)
      REMAP_8:  return (a & 16'hFF00) | ((a & 16'h001F) << 3) | ((a & 16'h00E0) >> 5);
      REMAP_9:  return (a & 16'hFE00) | ((a & 16'h003F) << 3) | ((a & 16'h01C0) >> 6);
      REMAP_10: return (a & 16'hFC00) | ((a & 16'h007F) << 3) | ((a & 16'h0380) >> 7);
      default:  return a;
    endcase
  endfunction

  function automatic logic [15:0] vram_stride(input logic [1:0] inc);
    if (inc == INC_1) return 16'd1;
    if (inc == INC_32) return 16'd32;
    return 16'd128;
  endfunction

  task automatic predict_write_command(input logic [5:0] off, input logic [7:0] d);
    mem_cmd_t    cmd;
    logic [15:0] w;
    logic        high;
    cmd = '{TGT_NONE, 16'h0000, 8'h00};
    case (off)
      OFF_OAM_ADDR_LO: oam_ptr = {7'b0, oam_ptr[8], d};
      OFF_OAM_ADDR_HI: oam_ptr = {7'b0, d[0], oam_ptr[7:0]};
      OFF_OAM_DATA: begin
        cmd.target = TGT_OAM;
        cmd.addr   = 16'(int'(oam_ptr) % SPRITE_BYTES_DEF);
        cmd.data   = d;
        oam_ptr    = oam_ptr + 16'd1;
      end
      OFF_VRAM_CTRL:    port_ctrl = d;
      OFF_VRAM_ADDR_LO: vram_ptr = {vram_ptr[15:8], d};
      OFF_VRAM_ADDR_HI: vram_ptr = {d, vram_ptr[7:0]};
      OFF_VRAM_DATA_LO, OFF_VRAM_DATA_HI: begin
        high       = (off == OFF_VRAM_DATA_HI);
        w          = scrambled_word(vram_ptr, port_ctrl[3:2]);
        cmd.target = TGT_VRAM;
        cmd.addr   = 16'(((int'(w) << 1) | int'(high)) % VRAM_BYTES_DEF);
        cmd.data   = d;
        // bit 7 picks which byte half advances the pointer
        if (port_ctrl[7] == high) vram_ptr = vram_ptr + vram_stride(port_ctrl[1:0]);
      end
      OFF_PAL_ADDR: begin
        pal_ptr  = d;
        pal_high = 1'b0;
      end
      OFF_PAL_DATA: begin
        cmd.target = TGT_PAL;
        cmd.addr   = 16'(int'({pal_ptr, pal_high}) % PALETTE_BYTES_DEF);
        if (pal_high) begin
          cmd.data = d & PAL_HIGH_MASK;
          pal_ptr  = pal_ptr + 8'd1;
        end else begin
          cmd.data = d;
        end
        pal_high = ~pal_high;
      end
      default: ;
    endcase
    expected_cmds.push_back(cmd);
  endtask

  task automatic check_write_command(input mem_cmd_t got);
    mem_cmd_t exp_cmd;
    if (expected_cmds.size() == 0) begin
      mismatch_count = mismatch_count + 1;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t: unexpected command target %0d addr %h data %h",
                 $realtime, got.target, got.addr, got.data);
      return;
    end
    exp_cmd = expected_cmds.pop_front();
    if (got.target !== exp_cmd.target || got.addr !== exp_cmd.addr ||
        got.data !== exp_cmd.data) begin
      mismatch_count = mismatch_count + 1;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t: mismatch expected target %0d addr %h data %h, got target %0d addr %h data %h",
                 $realtime, exp_cmd.target, exp_cmd.addr, exp_cmd.data,
                 got.target, got.addr, got.data);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      port_ctrl      = 8'h00;
      vram_ptr       = 16'h0000;
      oam_ptr        = 16'h0000;
      pal_ptr        = 8'h00;
      pal_high       = 1'b0;
      mismatch_count = 0;
      expected_cmds.delete();
    end else begin
      if (s_tvalid && s_tready) predict_write_command(s_tuser[5:0], s_tdata);
      if (m_tvalid && m_tready)
        check_write_command('{target_t'(m_tuser[1:0]), m_tdata[15:0], m_tdata[23:16]});
    end
    outstanding = expected_cmds.size();
  end

endmodule

// ===== tb/tb.sv =====
// top of the video memory write port testbench: clock, reset, register write
// stimulus with random gaps and stalls, and the final verdict
// depends on vmwp_pkg, video_memory_write_port_unit and vmwp_write_checker
`timescale 1ns / 100ps

module tb import vmwp_pkg::*;;

  localparam logic [5:0] OFF_UNUSED_LO = 6'h00;
  localparam logic [5:0] OFF_UNUSED_HI = 6'h3F;
  localparam logic [1:0] INC_128       = 2'd2;
  localparam logic [1:0] INC_128_ALT   = 2'd3;
  localparam int RANDOM_ITEMS = 1170;
  localparam int BURST_ITEMS  = 48;  // carries the sprite pointer from 511 past 544
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 600000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] write_data
  logic [7:0]  s_tuser = 8'h00;   // [5:0] reg_offset, [7:6] zero
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;           // [15:0] mem_address, [23:16] mem_data
  logic [7:0]  m_tuser;           // [1:0] target, [7:2] zero
  int          mismatch_count;
  int          outstanding;
  int          cycle_count = 0;
  bit          steady = 1'b0;     // no gaps or stalls while set

  video_memory_write_port_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  vmwp_write_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .mismatch_count(mismatch_count), .outstanding(outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int draw_wait();
    if (steady || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 10);
  endfunction

  function automatic logic [7:0] port_ctrl_byte(input logic high_first, input logic [1:0] mode,
                                                input logic [1:0] inc);
    return {high_first, 3'b000, mode, inc};
  endfunction

  // one register write transaction on the slave side
  task automatic send_reg_write(input logic [5:0] off, input logic [7:0] d);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= {2'b00, off};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_random_run(output int sent);
    int n;
    int kind;
    sent   = 0;
    kind   = $urandom_range(0, 9);
    steady = ($urandom_range(0, 7) == 0);
    n      = $urandom_range(1, 16);
    if (kind < 2) begin
      // noise: any offset, used or not
      repeat ($urandom_range(1, 4)) begin
        send_reg_write(6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
        sent++;
      end
    end else if (kind < 4) begin
      send_reg_write(OFF_OAM_ADDR_LO, 8'($urandom_range(0, 255)));
      send_reg_write(OFF_OAM_ADDR_HI, 8'($urandom_range(0, 255)));
      repeat (n) send_reg_write(OFF_OAM_DATA, 8'($urandom_range(0, 255)));
      sent = n + 2;
    end else if (kind < 7) begin
      if ($urandom_range(0, 1)) begin
        send_reg_write(OFF_VRAM_CTRL, 8'($urandom_range(0, 255)));
        sent++;
      end
      send_reg_write(OFF_VRAM_ADDR_LO, 8'($urandom_range(0, 255)));
      send_reg_write(OFF_VRAM_ADDR_HI, 8'($urandom_range(0, 255)));
      sent += 2;
      repeat (n) begin
        if ($urandom_range(0, 3) != 0) begin
          send_reg_write(OFF_VRAM_DATA_LO, 8'($urandom_range(0, 255)));
          send_reg_write(OFF_VRAM_DATA_HI, 8'($urandom_range(0, 255)));
          sent += 2;
        end else begin
          send_reg_write($urandom_range(0, 1) ? OFF_VRAM_DATA_HI : OFF_VRAM_DATA_LO,
                         8'($urandom_range(0, 255)));
          sent++;
        end
      end
    end else begin
      send_reg_write(OFF_PAL_ADDR, 8'($urandom_range(0, 255)));
      repeat (n) send_reg_write(OFF_PAL_DATA, 8'($urandom_range(0, 255)));
      sent = n + 1;
    end
  endtask

  // master side: random stall before each result transaction
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  initial begin
    int total;
    int sent;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: unused offsets, pointer extremes, wraps, every remap and stride
    send_reg_write(OFF_UNUSED_LO, 8'h00);
    send_reg_write(OFF_UNUSED_HI, 8'hFF);
    send_reg_write(OFF_OAM_ADDR_LO, 8'hFF);
    send_reg_write(OFF_OAM_ADDR_HI, 8'hFF);
    send_reg_write(OFF_OAM_DATA, 8'h00);
    send_reg_write(OFF_OAM_DATA, 8'hFF);
    send_reg_write(OFF_VRAM_CTRL, port_ctrl_byte(1'b0, REMAP_NONE, INC_1));
    send_reg_write(OFF_VRAM_ADDR_LO, 8'hFF);
    send_reg_write(OFF_VRAM_ADDR_HI, 8'hFF);
    send_reg_write(OFF_VRAM_DATA_LO, 8'hAA);
    send_reg_write(OFF_VRAM_DATA_HI, 8'h55);
    send_reg_write(OFF_VRAM_CTRL, port_ctrl_byte(1'b1, REMAP_8, INC_32));
    send_reg_write(OFF_VRAM_DATA_HI, 8'hFF);
    send_reg_write(OFF_VRAM_CTRL, port_ctrl_byte(1'b1, REMAP_9, INC_128));
    send_reg_write(OFF_VRAM_DATA_LO, 8'h00);
    send_reg_write(OFF_VRAM_DATA_HI, 8'h01);
    send_reg_write(OFF_VRAM_CTRL, port_ctrl_byte(1'b0, REMAP_10, INC_128_ALT) | 8'h70);
    send_reg_write(OFF_VRAM_DATA_LO, 8'h12);
    send_reg_write(OFF_PAL_ADDR, 8'hFF);
    send_reg_write(OFF_PAL_DATA, 8'hFF);
    send_reg_write(OFF_PAL_DATA, 8'hFF);
    send_reg_write(OFF_PAL_DATA, 8'h80);
    send_reg_write(OFF_PAL_ADDR, 8'h10);
    send_reg_write(OFF_PAL_DATA, 8'h34);

    // back-to-back sprite stores from the top of the settable range across the modulo boundary
    steady = 1'b1;
    send_reg_write(OFF_OAM_ADDR_LO, 8'hFF);
    send_reg_write(OFF_OAM_ADDR_HI, 8'h01);
    repeat (BURST_ITEMS) send_reg_write(OFF_OAM_DATA, 8'($urandom_range(0, 255)));

    total = 0;
    while (total < RANDOM_ITEMS) begin
      send_random_run(sent);
      total += sent;
    end
    steady = 1'b0;
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/vmwp_pkg.sv
rtl/video_memory_write_port_unit.sv
tb/vmwp_write_checker.sv
tb/tb.sv
